/* src/cfs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_pkg: shared types and codes of the circular FIFO with search
// Operation codes, result status codes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package cfs_pkg;

	localparam int WORD_W = 32;
	localparam int CAP_W  = 7;
	localparam int FUNC_W = 3;
	localparam int SLOT_W = 6;

	localparam logic [FUNC_W-1:0] FUNC_ENQ    = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_DEQ    = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_PEEK   = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_SEARCH = 3'd4;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    latch;      // capture the operation and its operand
		logic    enq;        // write at the tail, advance it, count up
		logic    deq_adv;    // advance the head, count down
		logic    clear;      // empty the queue
		logic    scan_init;  // start a search at the head
		logic    scan_step;  // move the search to the next slot
		logic    finish;     // load the result registers
		status_t res_status;
		logic    res_data;   // result carries the word read from storage
		logic    res_slot;   // result carries the current search slot
	} cfs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [FUNC_W-1:0] op;
		logic              empty;
		logic              full;
		logic              match;  // word read equals the search key
		logic              last;   // current search slot is the last stored one
	} cfs_stat_t;

endpackage

/* src/cfs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module cfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/cfs_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_datapath: pointers, count, storage and result registers
// Carries out the commands of the controller and reports queue status.
// ----------------------------------------------------------------------------
module cfs_datapath #(
	parameter int DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfs_pkg::cfs_cmd_t             cmd,
	output cfs_pkg::cfs_stat_t            stat,
	input  logic [cfs_pkg::FUNC_W-1:0]    func,
	input  logic [cfs_pkg::WORD_W-1:0]    value,
	input  logic                          cfg_we,
	input  logic [cfs_pkg::CAP_W-1:0]     cfg_data,
	output logic [1:0]                    status,
	output logic [cfs_pkg::WORD_W-1:0]    data_out,
	output logic [cfs_pkg::SLOT_W-1:0]    found_slot,
	output logic [cfs_pkg::CAP_W-1:0]     occupancy,
	output logic                          is_empty,
	output logic                          is_full
);

	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CW    = (AW + 1 > cfs_pkg::CAP_W) ? AW + 1 : cfs_pkg::CAP_W;
	localparam logic [cfs_pkg::CAP_W-1:0] EC_RST =
		cfs_pkg::CAP_W'((DEPTH < 64) ? DEPTH : 64);

	logic [cfs_pkg::FUNC_W-1:0] op_q;
	logic [cfs_pkg::WORD_W-1:0] key_q;
	logic [AW-1:0]              head_q, tail_q, scan_idx_q;
	logic [CNT_W-1:0]           count_q, scan_left_q;
	logic [cfs_pkg::CAP_W-1:0]  effcap_q, effcap_d;
	logic [1:0]                 status_q;
	logic [cfs_pkg::WORD_W-1:0] data_q;
	logic [cfs_pkg::SLOT_W-1:0] slot_q;
	logic [AW-1:0]              head_nxt, tail_nxt, scan_nxt, raddr;
	logic [cfs_pkg::WORD_W-1:0] rdata;

	// Next slot in the ring, wrapping at the effective capacity.
	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p,
			input logic [cfs_pkg::CAP_W-1:0] cap);
		logic [CW-1:0] n;
		n = CW'(p) + CW'(1);
		return (n >= CW'(cap)) ? '0 : AW'(n);
	endfunction

	assign head_nxt = ring_next(head_q, effcap_q);
	assign tail_nxt = ring_next(tail_q, effcap_q);
	assign scan_nxt = ring_next(scan_idx_q, effcap_q);
	assign raddr    = cmd.scan_step ? scan_nxt : head_q;

	// A capacity of zero acts as one; one above the built depth saturates.
	always_comb begin
		if (cfg_data == '0) begin
			effcap_d = cfs_pkg::CAP_W'(1);
		end else if (int'(cfg_data) > DEPTH) begin
			effcap_d = cfs_pkg::CAP_W'(DEPTH);
		end else begin
			effcap_d = cfg_data;
		end
	end

	cfs_ram #(
		.WIDTH (cfs_pkg::WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.enq),
		.waddr (tail_q),
		.wdata (key_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			effcap_q    <= EC_RST;
			scan_idx_q  <= '0;
			scan_left_q <= '0;
		end else begin
			if (cfg_we) begin
				effcap_q <= effcap_d;
			end
			if (cfg_we || cmd.clear) begin
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end else if (cmd.enq) begin
				tail_q  <= tail_nxt;
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.deq_adv) begin
				head_q  <= head_nxt;
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.scan_init) begin
				scan_idx_q  <= head_q;
				scan_left_q <= count_q;
			end else if (cmd.scan_step) begin
				scan_idx_q  <= scan_nxt;
				scan_left_q <= scan_left_q - CNT_W'(1);
			end
		end
	end

	// Operand and result registers carry payload only.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= func;
			key_q <= value;
		end
		if (cmd.finish) begin
			status_q <= cmd.res_status;
			data_q   <= cmd.res_data ? rdata : '0;
			slot_q   <= cmd.res_slot ? cfs_pkg::SLOT_W'(scan_idx_q) : '0;
		end
	end

	assign stat.op    = op_q;
	assign stat.empty = (count_q == '0);
	assign stat.full  = (CW'(count_q) >= CW'(effcap_q));
	assign stat.match = (rdata == key_q);
	assign stat.last  = (scan_left_q == CNT_W'(1));

	assign status     = status_q;
	assign data_out   = data_q;
	assign found_slot = slot_q;
	assign occupancy  = cfs_pkg::CAP_W'(count_q);
	assign is_empty   = stat.empty;
	assign is_full    = stat.full;

`ifndef SYNTH
	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(count_q) <= CW'(effcap_q))
		else $error("stored count exceeds the capacity in use");

	a_ptrs_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CW'(head_q) < CW'(effcap_q)) && (CW'(tail_q) < CW'(effcap_q)))
		else $error("head or tail pointer outside the capacity in use");
`endif

endmodule

/* src/cfs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_ctrl: operation sequencer of the circular FIFO with search
// Decodes each item, steers the datapath and raises the result strobe.
// ----------------------------------------------------------------------------
module cfs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  cfs_pkg::cfs_stat_t stat,
	output cfs_pkg::cfs_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DISPATCH,
		S_READ,
		S_SCAN
	} state_t;

	state_t state_q, state_d;
	logic   busy_q, done_q;

	always_comb begin
		cmd        = '0;
		cmd.res_status = cfs_pkg::ST_OK;
		state_d    = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.latch = start;
				if (start) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (stat.op) inside
					cfs_pkg::FUNC_ENQ: begin
						cmd.finish = 1'b1;
						if (stat.full) begin
							cmd.res_status = cfs_pkg::ST_FULL;
						end else begin
							cmd.enq = 1'b1;
						end
					end
					cfs_pkg::FUNC_DEQ, cfs_pkg::FUNC_PEEK: begin
						if (stat.empty) begin
							cmd.finish     = 1'b1;
							cmd.res_status = cfs_pkg::ST_EMPTY;
						end
					end
					cfs_pkg::FUNC_CLEAR: begin
						cmd.clear  = 1'b1;
						cmd.finish = 1'b1;
					end
					cfs_pkg::FUNC_SEARCH: begin
						if (stat.empty) begin
							cmd.finish     = 1'b1;
							cmd.res_status = cfs_pkg::ST_NOTFOUND;
						end else begin
							cmd.scan_init = 1'b1;
						end
					end
					default: begin
						cmd.finish = 1'b1;
					end
				endcase
				if (cmd.finish) begin
					state_d = S_IDLE;
				end else if (cmd.scan_init) begin
					state_d = S_SCAN;
				end else begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.finish   = 1'b1;
				cmd.res_data = 1'b1;
				cmd.deq_adv  = (stat.op == cfs_pkg::FUNC_DEQ);
				state_d      = S_IDLE;
			end
			S_SCAN: begin
				if (stat.match) begin
					cmd.finish   = 1'b1;
					cmd.res_slot = 1'b1;
					state_d      = S_IDLE;
				end else if (stat.last) begin
					cmd.finish     = 1'b1;
					cmd.res_status = cfs_pkg::ST_NOTFOUND;
					state_d        = S_IDLE;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
			done_q  <= cmd.finish;
		end
	end

	assign busy = busy_q;
	assign done = done_q;

`ifndef SYNTH
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe raised while an item is still in work");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted item did not make the block busy");

	a_one_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");
`endif

endmodule

/* src/circular_fifo_with_search_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_fifo_with_search_core: ring-buffer FIFO of signed words with search
// Enqueue, dequeue, peek, clear and a linear search from the head.
// ----------------------------------------------------------------------------
//
// An item is taken when start is high while busy is low; busy then stays high
// until the result is presented. Each result appears for exactly one cycle,
// marked by done, and must be captured then, as the block cannot be held off.
// Enqueue, clear, any unknown operation and every full or empty report finish
// in the dispatch state; dequeue and peek also pass through a read state,
// because the storage RAM has a registered read; a search steps through the
// scan state once for each stored word compared, so it compares at most as
// many words as are stored. The search compares one word per cycle against the
// RAM's single read port. A new item may be started in the cycle in which done
// is high. The occupancy, is_empty and is_full outputs always show the current
// queue state, which during the strobe cycle is the state after the operation.
// The capacity register is written through cfg_valid/cfg_ready while the block
// is idle; a write also empties the queue. A capacity of zero acts as one and a
// capacity above DEPTH acts as DEPTH. The storage is not cleared at reset; the
// pointers and the count ensure that only written words are ever returned.
//
module circular_fifo_with_search_core #(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	// Operation channel.
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         func,
	input  logic signed [31:0] value,
	// Result channel.
	output logic               done,
	output logic [1:0]         status,
	output logic signed [31:0] data_out,
	output logic [5:0]         found_slot,
	output logic [6:0]         occupancy,
	output logic               is_empty,
	output logic               is_full,
	// Capacity register write channel.
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [6:0]         cfg_data
);

	cfs_pkg::cfs_cmd_t  cmd;
	cfs_pkg::cfs_stat_t stat;
	logic [31:0]        data_word;

	// Configuration is taken whenever no item is in work.
	assign cfg_ready = !busy;

	cfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.stat   (stat),
		.cmd    (cmd)
	);

	cfs_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.func       (func),
		.value      (value),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.status     (status),
		.data_out   (data_word),
		.found_slot (found_slot),
		.occupancy  (occupancy),
		.is_empty   (is_empty),
		.is_full    (is_full)
	);

	assign data_out = signed'(data_word);

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for circular_fifo_with_search_core
// Operations go in through the start/busy handshake. An independent model of
// the ring buffer predicts every result, and each done strobe is checked field
// by field against the oldest prediction. The run steps through several queue
// capacities, including zero and values above the built depth.
// ----------------------------------------------------------------------------
module tb;

	localparam int DEPTH = 64;

	// One predicted result, at the widths of the result ports.
	typedef struct {
		cfs_pkg::status_t                  st;
		logic signed [cfs_pkg::WORD_W-1:0] word;
		logic [cfs_pkg::SLOT_W-1:0]        slot;
		logic [cfs_pkg::CAP_W-1:0]         occ;
		logic                              empty;
		logic                              full;
	} fifo_result_t;

	// Tracks the queue contents as the block should hold them. Every accepted
	// item is applied at once and its result is queued until the block's
	// strobe for it arrives.
	class fifo_tracker;
		logic [cfs_pkg::WORD_W-1:0] store [DEPTH];
		int unsigned                head;
		int unsigned                tail;
		int unsigned                count;
		logic [cfs_pkg::CAP_W-1:0]  cap_reg;
		fifo_result_t               awaited_results [$];
		int                         mismatches;

		function new();
			cap_reg    = cfs_pkg::CAP_W'(DEPTH);
			head       = 0;
			tail       = 0;
			count      = 0;
			mismatches = 0;
		endfunction

		// A capacity of zero acts as one; anything above the depth saturates.
		function int unsigned eff_cap();
			if (cap_reg == 0) return 1;
			if (cap_reg > DEPTH) return DEPTH;
			return cap_reg;
		endfunction

		function int unsigned next_slot(input int unsigned p);
			return (p + 1 >= eff_cap()) ? 0 : p + 1;
		endfunction

		// Writing the capacity also empties the queue.
		function void set_capacity(input logic [cfs_pkg::CAP_W-1:0] c);
			cap_reg = c;
			head    = 0;
			tail    = 0;
			count   = 0;
		endfunction

		function void note_item(input logic [cfs_pkg::FUNC_W-1:0] op,
				input logic [cfs_pkg::WORD_W-1:0] v);
			fifo_result_t r;
			int unsigned  c;
			int unsigned  i;
			int unsigned  idx;
			c      = eff_cap();
			r.st   = cfs_pkg::ST_OK;
			r.word = '0;
			r.slot = '0;
			case (op) inside
				cfs_pkg::FUNC_ENQ: begin
					if (count >= c) begin
						r.st = cfs_pkg::ST_FULL;
					end else begin
						store[tail] = v;
						tail        = next_slot(tail);
						count++;
					end
				end
				cfs_pkg::FUNC_DEQ, cfs_pkg::FUNC_PEEK: begin
					if (count == 0) begin
						r.st = cfs_pkg::ST_EMPTY;
					end else begin
						r.word = store[head];
						if (op == cfs_pkg::FUNC_DEQ) begin
							head = next_slot(head);
							count--;
						end
					end
				end
				cfs_pkg::FUNC_CLEAR: begin
					head  = 0;
					tail  = 0;
					count = 0;
				end
				cfs_pkg::FUNC_SEARCH: begin
					// Scan from the logical head; the first equal word wins.
					r.st = cfs_pkg::ST_NOTFOUND;
					for (i = 0; i < count && r.st != cfs_pkg::ST_OK; i++) begin
						idx = head + i;
						if (idx >= c) idx -= c;
						if (store[idx] == v) begin
							r.st   = cfs_pkg::ST_OK;
							r.slot = cfs_pkg::SLOT_W'(idx);
						end
					end
				end
				default: begin
				end
			endcase
			r.occ   = cfs_pkg::CAP_W'(count);
			r.empty = (count == 0);
			r.full  = (count >= c);
			awaited_results.push_back(r);
		endfunction

		task report(input string msg);
			if (mismatches < 50) $display("MISMATCH at %0t ns: %s", $time, msg);
			mismatches++;
		endtask

		task check_result(input logic [1:0] st, input logic [cfs_pkg::WORD_W-1:0] word,
				input logic [cfs_pkg::SLOT_W-1:0] slot,
				input logic [cfs_pkg::CAP_W-1:0] occ,
				input logic empty, input logic full);
			fifo_result_t e;
			if (awaited_results.size() == 0) begin
				report("result strobe with no item outstanding");
				return;
			end
			e = awaited_results.pop_front();
			if (st !== e.st) report($sformatf("status %0d, expected %0d", st, e.st));
			if (word !== e.word)
				report($sformatf("data_out %h, expected %h", word, e.word));
			if (slot !== e.slot)
				report($sformatf("found_slot %0d, expected %0d", slot, e.slot));
			if (occ !== e.occ)
				report($sformatf("occupancy %0d, expected %0d", occ, e.occ));
			if (empty !== e.empty)
				report($sformatf("is_empty %b, expected %b", empty, e.empty));
			if (full !== e.full)
				report($sformatf("is_full %b, expected %b", full, e.full));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [2:0]         func;
	logic signed [31:0] value;
	logic               done;
	logic [1:0]         status;
	logic signed [31:0] data_out;
	logic [5:0]         found_slot;
	logic [6:0]         occupancy;
	logic               is_empty;
	logic               is_full;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [6:0]         cfg_data;

	fifo_tracker model = new();

	// Capacities visited by the random part: the smallest ones, zero (which acts
	// as one), the full depth and values above it that must saturate.
	logic [cfs_pkg::CAP_W-1:0] phase_caps [12] = '{7'd1, 7'd2, 7'd3, 7'd64, 7'd5,
		7'd127, 7'd16, 7'd65, 7'd7, 7'd64, 7'd40, 7'd0};

	circular_fifo_with_search_core #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.value      (value),
		.done       (done),
		.status     (status),
		.data_out   (data_out),
		.found_slot (found_slot),
		.occupancy  (occupancy),
		.is_empty   (is_empty),
		.is_full    (is_full),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The block cannot be held off, so every strobe is checked on the edge that
	// ends its cycle.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			model.check_result(status, data_out, found_slot, occupancy, is_empty, is_full);
	end

	// Mostly back-to-back items, some short pauses and now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Words come from the extremes, from a small pool so that duplicates are
	// common, or from the whole range.
	function automatic logic [cfs_pkg::WORD_W-1:0] pick_word();
		int r;
		r = $urandom_range(9);
		if (r == 0) begin
			case ($urandom_range(3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return '0;
				default: return '1;
			endcase
		end
		if (r < 5) return cfs_pkg::WORD_W'($urandom_range(7));
		return $urandom();
	endfunction

	// Most search keys are taken from a random position among the stored words,
	// so that matches are found at every depth of the scan.
	function automatic logic [cfs_pkg::WORD_W-1:0] search_key();
		int unsigned idx;
		if (model.count > 0 && $urandom_range(99) < 60) begin
			idx = model.head + $urandom_range(model.count - 1);
			if (idx >= model.eff_cap()) idx -= model.eff_cap();
			return model.store[idx];
		end
		return pick_word();
	endfunction

	// Presents one item after the requested number of idle cycles and returns
	// on the edge at which the block takes it. start stays high afterwards so
	// that a following item with no gap goes in back to back.
	task automatic send_item(input logic [cfs_pkg::FUNC_W-1:0] op,
			input logic [cfs_pkg::WORD_W-1:0] word, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		func  <= op;
		value <= word;
		do @(posedge clk); while (busy !== 1'b0);
		model.note_item(op, word);
	endtask

	// Stops sending and waits until every outstanding result has come back.
	task automatic hold_off();
		@(negedge clk);
		start <= 1'b0;
		while (model.awaited_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [cfs_pkg::CAP_W-1:0] c);
		hold_off();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= c;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		model.set_capacity(c);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One random phase at a given capacity. The mix alternates between filling
	// and draining so that the queue reaches both full and empty, wraps around,
	// and sees enqueues while full and dequeues while empty.
	task automatic run_phase(input logic [cfs_pkg::CAP_W-1:0] c);
		int                         budget;
		int                         taken;
		int                         r;
		bit                         filling;
		bit                         quiet;
		logic [cfs_pkg::FUNC_W-1:0] op;
		logic [cfs_pkg::WORD_W-1:0] word;
		write_capacity(c);
		budget  = 40 + 2 * model.eff_cap();
		taken   = 0;
		filling = 1'b1;
		quiet   = ($urandom_range(3) == 0);
		while (taken < budget) begin
			if (filling && model.count >= model.eff_cap() && $urandom_range(99) < 30)
				filling = 1'b0;
			else if (!filling && model.count == 0 && $urandom_range(99) < 30)
				filling = 1'b1;
			r = $urandom_range(99);
			if (filling)
				op = (r < 72) ? cfs_pkg::FUNC_ENQ : (r < 80) ? cfs_pkg::FUNC_DEQ :
					(r < 85) ? cfs_pkg::FUNC_PEEK : (r < 97) ? cfs_pkg::FUNC_SEARCH :
					(r < 98) ? cfs_pkg::FUNC_CLEAR :
					cfs_pkg::FUNC_SEARCH + cfs_pkg::FUNC_W'($urandom_range(3, 1));
			else
				op = (r < 15) ? cfs_pkg::FUNC_ENQ : (r < 70) ? cfs_pkg::FUNC_DEQ :
					(r < 78) ? cfs_pkg::FUNC_PEEK : (r < 97) ? cfs_pkg::FUNC_SEARCH :
					(r < 98) ? cfs_pkg::FUNC_CLEAR :
					cfs_pkg::FUNC_SEARCH + cfs_pkg::FUNC_W'($urandom_range(3, 1));
			word = (op == cfs_pkg::FUNC_SEARCH) ? search_key() : pick_word();
			// Occasionally let the block run completely dry mid-phase.
			if ($urandom_range(199) == 0) hold_off();
			send_item(op, word, quiet ? 0 : pick_gap());
			if (op <= cfs_pkg::FUNC_SEARCH) taken++;
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		func      = cfs_pkg::FUNC_ENQ;
		value     = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed part at the reset capacity: reports on an empty queue, the
		// unused operation codes, extreme words, search hits and misses, clear.
		send_item(cfs_pkg::FUNC_DEQ, '0, 0);
		send_item(cfs_pkg::FUNC_PEEK, '0, 0);
		send_item(cfs_pkg::FUNC_SEARCH, '0, 0);
		send_item(cfs_pkg::FUNC_SEARCH + cfs_pkg::FUNC_W'(1), $urandom(), 0);
		send_item(cfs_pkg::FUNC_SEARCH + cfs_pkg::FUNC_W'(2), $urandom(), 1);
		send_item(cfs_pkg::FUNC_SEARCH + cfs_pkg::FUNC_W'(3), $urandom(), 0);
		send_item(cfs_pkg::FUNC_ENQ, 32'h8000_0000, 0);
		send_item(cfs_pkg::FUNC_ENQ, 32'h7FFF_FFFF, 0);
		send_item(cfs_pkg::FUNC_ENQ, 32'hFFFF_FFFF, 2);
		send_item(cfs_pkg::FUNC_ENQ, 32'h0000_0000, 0);
		send_item(cfs_pkg::FUNC_PEEK, '0, 0);
		send_item(cfs_pkg::FUNC_SEARCH, 32'hFFFF_FFFF, 0);
		send_item(cfs_pkg::FUNC_SEARCH, 32'h1234_5678, 0);
		send_item(cfs_pkg::FUNC_DEQ, '0, 0);
		send_item(cfs_pkg::FUNC_SEARCH, 32'h8000_0000, 3);
		send_item(cfs_pkg::FUNC_SEARCH, 32'h7FFF_FFFF, 0);
		send_item(cfs_pkg::FUNC_CLEAR, '0, 0);
		send_item(cfs_pkg::FUNC_DEQ, '0, 0);

		// A written capacity of zero behaves as a single slot: full after one
		// enqueue, and the tail wraps straight back to slot zero.
		write_capacity('0);
		send_item(cfs_pkg::FUNC_ENQ, 32'h0000_0005, 0);
		send_item(cfs_pkg::FUNC_ENQ, 32'h0000_0006, 0);
		send_item(cfs_pkg::FUNC_SEARCH, 32'h0000_0005, 0);
		send_item(cfs_pkg::FUNC_PEEK, '0, 0);
		send_item(cfs_pkg::FUNC_DEQ, '0, 0);
		send_item(cfs_pkg::FUNC_ENQ, 32'h0000_0007, 0);
		send_item(cfs_pkg::FUNC_SEARCH, 32'h0000_0005, 0);

		foreach (phase_caps[p]) run_phase(phase_caps[p]);

		// Everything is in; wait for the last results and a little beyond, so
		// that a stray strobe would still be caught.
		hold_off();
		repeat (10) @(posedge clk);
		if (model.mismatches == 0)
			$display("** circular_fifo_with_search_core: PASSED **");
		else
			$display("** circular_fifo_with_search_core: FAILED **");
		$finish;
	end

	// Far beyond the slowest correct run: every item a full-length search after
	// the longest pause.
	initial begin
		#10_000_000;
		$display("TIMEOUT at %0t ns", $time);
		$display("** circular_fifo_with_search_core: FAILED **");
		$finish;
	end

endmodule
